// ===== hw/rtl/rrgt_pkg.sv =====
// rrgt_pkg: shared widths, register codes, reset values and saturation limits
// for the range gate tracker; no dependencies
package rrgt_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 33;
    localparam int WLEN_W     = 13;
    localparam int GATE_W     = 24;
    localparam int SCALE_W    = 24;
    localparam int RANGE_W    = 48;
    localparam int CFG_DATA_W = 24;

    // configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_WINDOW_LENGTH = 2'd0;
    localparam cfg_index_t CFG_INIT_GATE     = 2'd1;
    localparam cfg_index_t CFG_RANGE_SCALE   = 2'd2;

    // register reset values
    localparam logic [WLEN_W-1:0]         WLEN_RESET      = 13'd100;
    localparam logic signed [GATE_W-1:0]  INIT_GATE_RESET = 24'sd200;
    localparam logic [SCALE_W-1:0]        SCALE_RESET     = 24'd30720;

    // saturation limits
    localparam logic signed [GATE_W-1:0]  GATE_MAX  = 24'sh7F_FFFF;
    localparam logic signed [GATE_W-1:0]  GATE_MIN  = 24'sh80_0000;
    localparam logic signed [RANGE_W-1:0] RANGE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [RANGE_W-1:0] RANGE_MIN = 48'sh8000_0000_0000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GATE_W-1:0]   gate_t;
    typedef logic signed [RANGE_W-1:0]  range_t;

endpackage

// ===== hw/rtl/rrgt_in_if.sv =====
// rrgt_in_if: input sample channel, valid/ready with track flag and I/Q payload
// depends on rrgt_pkg
interface rrgt_in_if import rrgt_pkg::*; ();

    logic    valid;
    logic    ready;
    logic    track_enable;
    sample_t sample_i;
    sample_t sample_q;

    modport source (output valid, track_enable, sample_i, sample_q, input ready);
    modport sink   (input valid, track_enable, sample_i, sample_q, output ready);

endinterface

// ===== hw/rtl/rrgt_out_if.sv =====
// rrgt_out_if: result channel, valid/ready with samples, range and gate payload
// depends on rrgt_pkg
interface rrgt_out_if import rrgt_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t out_i;
    sample_t out_q;
    logic    window_last;
    range_t  target_range;
    gate_t   gate_start_out;

    modport source (output valid, out_i, out_q, window_last, target_range, gate_start_out,
                    input ready);
    modport sink   (input valid, out_i, out_q, window_last, target_range, gate_start_out,
                    output ready);

endinterface

// ===== hw/rtl/radar_range_gate_tracker.sv =====
// radar_range_gate_tracker: each accepted item yields one result item
// throughput one item per cycle while the sink takes results; a three-register pipeline (square, peak/gate, multiply)
// ready drops only while a result item is held by the sink and the pipeline is full
// reset clears the pipeline, sample position and peak, loads register defaults
// and sets the stored gate to the init_gate_start default (200)
// depends on rrgt_pkg, rrgt_in_if, rrgt_out_if
module radar_range_gate_tracker import rrgt_pkg::*; #(
    parameter int MAX_WINDOW = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    rrgt_in_if.sink               samples,
    rrgt_out_if.source            results
);

    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int CW  = (PW + 1 > WLEN_W) ? PW + 1 : WLEN_W;
    localparam int OW  = ((PW + 2 > GATE_W) ? PW + 2 : GATE_W) + 1;
    localparam int GW  = OW + 1;
    localparam int PRW = SCALE_W + 1 + OW;

    // configuration registers
    logic [WLEN_W-1:0]  wlen_reg;
    gate_t              init_gate_reg;
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            init_gate_reg <= INIT_GATE_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: wlen_reg      <= cfg_wdata[WLEN_W-1:0];
                CFG_INIT_GATE:     init_gate_reg <= $signed(cfg_wdata[GATE_W-1:0]);
                CFG_RANGE_SCALE:   scale_reg     <= cfg_wdata[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline control
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic adv_a, adv_b, adv_c, b_load;

    assign adv_c = !c_valid_reg || results.ready;
    assign adv_b = !b_valid_reg || adv_c;
    assign adv_a = !a_valid_reg || adv_b;
    assign b_load = a_valid_reg && adv_b;
    assign samples.ready = adv_a;

    // stage a: register the item and its squared magnitude
    logic              a_track_reg;
    sample_t           a_i_reg, a_q_reg;
    logic [MAG_W-1:0]  a_mag_reg;
    logic signed [2*SAMPLE_W-1:0] sq_i, sq_q;
    logic [MAG_W-1:0]  mag_next;

    assign sq_i = samples.sample_i * samples.sample_i;
    assign sq_q = samples.sample_q * samples.sample_q;
    assign mag_next = MAG_W'($unsigned(sq_i)) + MAG_W'($unsigned(sq_q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv_a)
            a_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_track_reg <= samples.track_enable;
            a_i_reg     <= samples.sample_i;
            a_q_reg     <= samples.sample_q;
            a_mag_reg   <= mag_next;
        end
    end

    // stage b: window state, peak search and gate update
    logic [PW-1:0]    pos_reg;
    logic [MAG_W-1:0] peak_mag_reg;
    logic [PW-1:0]    peak_pos_reg;
    gate_t            gate_reg;
    logic             track_reg;

    logic                 first, tracking, hit, last;
    logic [MAG_W-1:0]     cur_mag, peak_mag_next;
    logic [PW-1:0]        cur_pos, peak_pos_next;
    logic [CW-1:0]        wlen_ext, len_eff, pos_inc;
    logic signed [OW-1:0] twice_pos, offset;
    logic signed [GW-1:0] gate_sum;
    gate_t                gate_sat;

    assign first    = (pos_reg == '0);
    assign tracking = first ? a_track_reg : track_reg;
    assign cur_mag  = first ? '0 : peak_mag_reg;
    assign cur_pos  = first ? '0 : peak_pos_reg;
    assign hit      = a_mag_reg > cur_mag;
    assign peak_mag_next = hit ? a_mag_reg : cur_mag;
    assign peak_pos_next = hit ? pos_reg : cur_pos;

    // effective window length, clamped to 1..MAX_WINDOW
    assign wlen_ext = CW'(wlen_reg);
    always_comb
    begin
        if (wlen_ext == '0)
            len_eff = CW'(1);
        else if (wlen_ext > CW'(MAX_WINDOW))
            len_eff = CW'(MAX_WINDOW);
        else
            len_eff = wlen_ext;
    end

    assign pos_inc = CW'(pos_reg) + CW'(1);
    assign last    = pos_inc >= len_eff;

    // range offset and moved gate with saturation
    assign twice_pos = $signed(OW'({peak_pos_next, 1'b0}));
    assign offset    = twice_pos + OW'(gate_reg);
    assign gate_sum  = GW'(offset) - $signed(GW'(len_eff));

    always_comb
    begin
        if (gate_sum > GW'(GATE_MAX))
            gate_sat = GATE_MAX;
        else if (gate_sum < GW'(GATE_MIN))
            gate_sat = GATE_MIN;
        else
            gate_sat = gate_sum[GATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            peak_mag_reg <= '0;
            peak_pos_reg <= '0;
            gate_reg     <= INIT_GATE_RESET;
            track_reg    <= 1'b0;
        end
        else if (b_load)
        begin
            track_reg    <= tracking;
            peak_mag_reg <= peak_mag_next;
            peak_pos_reg <= peak_pos_next;
            pos_reg      <= last ? '0 : pos_inc[PW-1:0];
            if (last && tracking)
                gate_reg <= gate_sat;
        end
    end

    logic                 b_track_reg, b_last_reg;
    sample_t              b_i_reg, b_q_reg;
    logic signed [OW-1:0] b_offset_reg;
    gate_t                b_gate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv_b)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_track_reg  <= tracking;
            b_last_reg   <= last;
            b_i_reg      <= tracking ? a_i_reg : '0;
            b_q_reg      <= tracking ? a_q_reg : '0;
            b_offset_reg <= offset;
            if (!last)
                b_gate_reg <= '0;
            else if (tracking)
                b_gate_reg <= gate_sat;
            else
                b_gate_reg <= init_gate_reg;
        end
    end

    // stage c: range multiply and saturation into the result register
    logic signed [PRW-1:0] product;
    range_t                range_sat;

    assign product = $signed({1'b0, scale_reg}) * b_offset_reg;

    always_comb
    begin
        if (product > PRW'(RANGE_MAX))
            range_sat = RANGE_MAX;
        else if (product < PRW'(RANGE_MIN))
            range_sat = RANGE_MIN;
        else
            range_sat = product[RANGE_W-1:0];
    end

    logic    c_track_reg, c_last_reg;
    sample_t c_i_reg, c_q_reg;
    range_t  c_range_reg;
    gate_t   c_gate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv_c)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_c && b_valid_reg)
        begin
            c_track_reg <= b_track_reg;
            c_last_reg  <= b_last_reg;
            c_i_reg     <= b_i_reg;
            c_q_reg     <= b_q_reg;
            c_range_reg <= (b_last_reg && b_track_reg) ? range_sat : '0;
            c_gate_reg  <= b_gate_reg;
        end
    end

    // result item
    assign results.valid          = c_valid_reg;
    assign results.out_i          = c_i_reg;
    assign results.out_q          = c_q_reg;
    assign results.window_last    = c_last_reg;
    assign results.target_range   = c_range_reg;
    assign results.gate_start_out = c_gate_reg;

    // checks
    a_mid_window_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !c_last_reg |-> c_range_reg == '0 && c_gate_reg == '0)
        else $error("range or gate nonzero inside a window");

    a_untracked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && !c_track_reg |-> c_i_reg == '0 && c_q_reg == '0 && c_range_reg == '0)
        else $error("untracked window passed data");

    a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        b_load && last |=> pos_reg == '0)
        else $error("sample position did not wrap at window end");

    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        b_load && !last |=> pos_reg != '0)
        else $error("sample position did not advance");

endmodule

// ===== test/radar_range_gate_tracker_tb.sv =====
// radar_range_gate_tracker_tb: self-checking bench for the range gate tracker
// drives I/Q items with random gaps and stalls, predicts every result item and compares
// depends on rrgt_pkg, rrgt_in_if, rrgt_out_if and radar_range_gate_tracker
module radar_range_gate_tracker_tb import rrgt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIN      = 4096;
    localparam int PIPE_LAT     = 3;
    localparam int ITEM_TARGET  = 1250;
    localparam int QUIET_LIMIT  = 1000;
    localparam int REPORT_LIMIT = 10;

    // index that maps to no register
    localparam cfg_index_t CFG_UNMAPPED = 2'd3;

    typedef enum int { WIN_NOISE, WIN_ZERO, WIN_FLAT, WIN_SPIKE, WIN_EXTREME } window_shape_t;
    typedef enum int { IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_TAKE } idle_mode_t;

    typedef struct {
        logic    track;
        sample_t si;
        sample_t sq;
    } iq_item_t;

    typedef struct {
        sample_t i;
        sample_t q;
        logic    last;
        range_t  range;
        gate_t   gate;
    } track_result_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b1;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rrgt_in_if  samples ();
    rrgt_out_if results ();

    radar_range_gate_tracker #(
        .MAX_WINDOW (MAX_WIN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .samples   (samples),
        .results   (results)
    );

    // register copies
    logic [WLEN_W-1:0]  wlen_reg      = WLEN_RESET;
    gate_t              init_gate_reg = INIT_GATE_RESET;
    logic [SCALE_W-1:0] scale_reg     = SCALE_RESET;

    // tracker state copies
    logic [11:0]        win_pos     = '0;
    logic [MAG_W-1:0]   best_mag    = '0;
    logic [11:0]        best_pos    = '0;
    gate_t              gate_reg    = INIT_GATE_RESET;
    logic               win_tracked = 1'b0;

    iq_item_t      sample_backlog[$];
    track_result_t predicted_outputs[$];
    iq_item_t      on_bus;
    track_result_t want;
    track_result_t got;

    int queued_count   = 0;
    int checked_count  = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int send_gap_max   = 0;
    int take_stall_max = 0;
    int gap_left       = 0;
    int stall_left     = 0;

    always #5 clk = ~clk;

    // window length as the block sees it
    function automatic int unsigned active_length();
        if (wlen_reg == '0)
            return 1;
        if (wlen_reg > MAX_WIN)
            return MAX_WIN;
        return wlen_reg;
    endfunction

    // advance the tracker by one item and return the result it produces
    function automatic track_result_t track_sample(iq_item_t s);
        track_result_t r;
        int unsigned   len;
        longint        mag;
        longint        offs;
        longint        rng;
        longint        g;
        logic          ends;
        len = active_length();
        if (win_pos == '0)
        begin
            win_tracked = s.track;
            best_mag    = '0;
            best_pos    = '0;
        end
        mag = longint'(s.si) * longint'(s.si) + longint'(s.sq) * longint'(s.sq);
        if (mag > best_mag)
        begin
            best_mag = mag[MAG_W-1:0];
            best_pos = win_pos;
        end
        ends   = (win_pos + 1 >= len);
        r.i    = win_tracked ? s.si : '0;
        r.q    = win_tracked ? s.sq : '0;
        r.last = ends;
        r.range = '0;
        r.gate  = '0;
        if (ends)
        begin
            if (win_tracked)
            begin
                offs = 2 * longint'(best_pos) + longint'(gate_reg);
                rng  = longint'(scale_reg) * offs;
                if (rng > longint'(RANGE_MAX))
                    rng = longint'(RANGE_MAX);
                if (rng < longint'(RANGE_MIN))
                    rng = longint'(RANGE_MIN);
                g = longint'(gate_reg) + 2 * longint'(best_pos) - longint'(len);
                if (g > longint'(GATE_MAX))
                    g = longint'(GATE_MAX);
                if (g < longint'(GATE_MIN))
                    g = longint'(GATE_MIN);
                gate_reg = gate_t'(g);
                r.range  = range_t'(rng);
                r.gate   = gate_reg;
            end
            else
            begin
                r.gate = init_gate_reg;
            end
            win_pos = '0;
        end
        else
        begin
            win_pos = win_pos + 1'b1;
        end
        return r;
    endfunction

    function automatic sample_t rand_level();
        return sample_t'($urandom_range(0, 65535));
    endfunction

    function automatic sample_t edge_level();
        case ($urandom_range(0, 5))
            0:       return sample_t'(16'h8000);
            1:       return sample_t'(16'h8001);
            2:       return sample_t'(16'hFFFF);
            3:       return sample_t'(16'h0000);
            4:       return sample_t'(16'h0001);
            default: return sample_t'(16'h7FFF);
        endcase
    endfunction

    function automatic void push_item(logic trk, sample_t vi, sample_t vq);
        sample_backlog.push_back('{track: trk, si: vi, sq: vq});
        queued_count++;
    endfunction

    // one window's worth of items with a chosen magnitude profile
    function automatic void push_window(int n, window_shape_t shape);
        int      spike_at;
        int      twin_at;
        sample_t a;
        sample_t b;
        sample_t vi;
        sample_t vq;
        a        = rand_level();
        b        = rand_level();
        spike_at = $urandom_range(0, n - 1);
        twin_at  = (n > 1 && $urandom_range(0, 1) == 1) ? $urandom_range(spike_at, n - 1) : -1;
        for (int k = 0; k < n; k++)
        begin
            case (shape)
                WIN_ZERO:
                begin
                    vi = '0;
                    vq = '0;
                end
                WIN_FLAT:
                begin
                    // sign and swap permutations keep the magnitude equal
                    case ($urandom_range(0, 7))
                        0:       begin vi = a;  vq = b;  end
                        1:       begin vi = -a; vq = b;  end
                        2:       begin vi = a;  vq = -b; end
                        3:       begin vi = -a; vq = -b; end
                        4:       begin vi = b;  vq = a;  end
                        5:       begin vi = -b; vq = a;  end
                        6:       begin vi = b;  vq = -a; end
                        default: begin vi = -b; vq = -a; end
                    endcase
                end
                WIN_SPIKE:
                begin
                    if (k == spike_at || k == twin_at)
                    begin
                        vi = a;
                        vq = b;
                    end
                    else
                    begin
                        vi = sample_t'(int'($urandom_range(0, 32)) - 16);
                        vq = sample_t'(int'($urandom_range(0, 32)) - 16);
                    end
                end
                WIN_EXTREME:
                begin
                    vi = edge_level();
                    vq = edge_level();
                end
                default:
                begin
                    vi = rand_level();
                    vq = rand_level();
                end
            endcase
            push_item($urandom_range(0, 3) != 0, vi, vq);
        end
    endfunction

    function automatic void set_idle(idle_mode_t mode);
        send_gap_max   = (mode == IDLE_BOTH || mode == IDLE_SEND) ? 9 : 0;
        take_stall_max = (mode == IDLE_BOTH || mode == IDLE_TAKE) ? 9 : 0;
    endfunction

    // one register write pulse, mirrored into the register copies
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_WINDOW_LENGTH: wlen_reg      = data[WLEN_W-1:0];
            CFG_INIT_GATE:     init_gate_reg = gate_t'(data);
            CFG_RANGE_SCALE:   scale_reg     = data[SCALE_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // every queued item has produced its result, then the pipeline settles
    task automatic wait_drained();
        do
            @(posedge clk);
        while (checked_count != queued_count);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples.valid        <= 1'b0;
            samples.track_enable <= 1'b0;
            samples.sample_i     <= '0;
            samples.sample_q     <= '0;
            gap_left = 0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                predicted_outputs.push_back(track_sample(on_bus));
                gap_left = $urandom_range(0, send_gap_max);
            end
            if (!samples.valid || samples.ready)
            begin
                if (gap_left == 0 && sample_backlog.size() != 0)
                begin
                    on_bus = sample_backlog.pop_front();
                    samples.valid        <= 1'b1;
                    samples.track_enable <= on_bus.track;
                    samples.sample_i     <= on_bus.si;
                    samples.sample_q     <= on_bus.sq;
                end
                else
                begin
                    samples.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
            end
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got.i     = results.out_i;
                got.q     = results.out_q;
                got.last  = results.window_last;
                got.range = results.target_range;
                got.gate  = results.gate_start_out;
                if (predicted_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result item: i=%0d q=%0d last=%0b range=%0d gate=%0d",
                                 got.i, got.q, got.last, got.range, got.gate);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (got.i !== want.i || got.q !== want.q || got.last !== want.last ||
                        got.range !== want.range || got.gate !== want.gate)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"result item %0d mismatch: expected i=%0d q=%0d last=%0b",
                                      " range=%0d gate=%0d, got i=%0d q=%0d last=%0b",
                                      " range=%0d gate=%0d"},
                                     checked_count, want.i, want.q, want.last, want.range,
                                     want.gate, got.i, got.q, got.last, got.range, got.gate);
                    end
                    checked_count++;
                end
                stall_left = $urandom_range(0, take_stall_max);
            end
            if (stall_left != 0)
            begin
                results.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (samples.valid && samples.ready) || (results.valid && results.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("radar_range_gate_tracker_tb: errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned           wl;
        int unsigned           n;
        int unsigned           phase_goal;
        int unsigned           phase_items;
        logic [WLEN_W-1:0]     len_word;
        logic [CFG_DATA_W-1:0] word;

        cfg_we    <= 1'b0;
        cfg_index <= CFG_WINDOW_LENGTH;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(IDLE_BOTH);

        // length four windows, extreme gate and scale, junk above the length field
        write_reg(CFG_WINDOW_LENGTH, {11'h5A5, 13'd4});
        write_reg(CFG_INIT_GATE, GATE_MIN);
        write_reg(CFG_RANGE_SCALE, 24'hFFFFFF);
        // tracked, full-scale peaks with a tie: first of the equal peaks wins
        push_item(1'b1, 16'sd0, 16'sd0);
        push_item(1'b0, sample_t'(16'h8000), sample_t'(16'h8000));
        push_item(1'b1, 16'sd32767, 16'sd32767);
        push_item(1'b0, sample_t'(16'h8000), sample_t'(16'h8000));
        // untracked window, flag raised after the first item is ignored
        push_item(1'b0, 16'sd32767, sample_t'(16'h8000));
        push_item(1'b1, 16'sd1, -16'sd1);
        push_item(1'b1, -16'sd1, 16'sd1);
        push_item(1'b1, 16'sd0, 16'sd0);
        // all-zero tracked window
        repeat (4) push_item(1'b1, 16'sd0, 16'sd0);
        // equal magnitudes through sign and swap
        push_item(1'b1, 16'sd3, 16'sd4);
        push_item(1'b0, -16'sd4, 16'sd3);
        push_item(1'b1, 16'sd5, 16'sd0);
        push_item(1'b0, 16'sd0, -16'sd5);
        wait_drained();

        // single-item windows, top gate, zero scale
        write_reg(CFG_WINDOW_LENGTH, 24'd1);
        write_reg(CFG_INIT_GATE, GATE_MAX);
        write_reg(CFG_RANGE_SCALE, '0);
        push_item(1'b1, 16'sd12, -16'sd7);
        push_item(1'b0, sample_t'(16'h8000), 16'sd0);
        push_item(1'b1, 16'sd0, 16'sd32767);
        push_item(1'b0, 16'sd7, 16'sd7);
        wait_drained();

        // zero length acts as one, write to an unmapped index is dropped
        write_reg(CFG_WINDOW_LENGTH, {11'h7FF, 13'd0});
        write_reg(CFG_UNMAPPED, 24'hFFFFFF);
        write_reg(CFG_RANGE_SCALE, SCALE_RESET);
        push_item(1'b1, 16'sd100, -16'sd200);
        push_item(1'b1, -16'sd300, 16'sd5);
        wait_drained();

        // long windows cut short by a smaller length mid-window
        set_idle(IDLE_NONE);
        write_reg(CFG_WINDOW_LENGTH, {11'h001, 13'h1FFF});
        push_window(37, WIN_NOISE);
        wait_drained();
        write_reg(CFG_WINDOW_LENGTH, 24'd5);
        push_window(5, WIN_SPIKE);
        wait_drained();
        set_idle(IDLE_SEND);
        write_reg(CFG_WINDOW_LENGTH, 24'd4096);
        push_window(30, WIN_SPIKE);
        wait_drained();
        write_reg(CFG_WINDOW_LENGTH, 24'd1);
        push_window(3, WIN_NOISE);

        // random phases: new settings and idle pattern, then windows of random content
        while (queued_count < ITEM_TARGET)
        begin
            wait_drained();
            set_idle(idle_mode_t'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0:       len_word = 13'd1;
                1:       len_word = 13'd2;
                2:       len_word = 13'($urandom_range(3, 8));
                7:       len_word = 13'($urandom_range(25, 64));
                8:       len_word = 13'd0;
                9:       len_word = 13'($urandom_range(65, 128));
                default: len_word = 13'($urandom_range(3, 24));
            endcase
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_WINDOW_LENGTH, {11'($urandom_range(0, 2047)), len_word});
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       word = GATE_MIN;
                    1:       word = GATE_MAX;
                    2:       word = CFG_DATA_W'($urandom());
                    default: word = CFG_DATA_W'(int'($urandom_range(0, 2000)) - 1000);
                endcase
                write_reg(CFG_INIT_GATE, word);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       word = '0;
                    1:       word = 24'hFFFFFF;
                    2:       word = CFG_DATA_W'($urandom());
                    default: word = CFG_DATA_W'($urandom_range(1, 65535));
                endcase
                write_reg(CFG_RANGE_SCALE, word);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom()));
            phase_goal  = $urandom_range(40, 120);
            phase_items = 0;
            while (phase_items < phase_goal)
            begin
                wl = active_length();
                // mostly whole windows, now and then a run of odd length
                n  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2 * wl) : wl;
                push_window(n, window_shape_t'($urandom_range(0, 4)));
                phase_items += n;
            end
        end

        wait_drained();
        if (fail_count == 0 && predicted_outputs.size() == 0)
            $display("radar_range_gate_tracker_tb: clean");
        else
            $display("radar_range_gate_tracker_tb: errors");
        $finish;
    end

endmodule
